@@ design/path_history_fold_hash_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the path history fold/hash top-level design file
// ---------------------------------------------------------------------------
`ifndef PATH_HISTORY_FOLD_HASH_ASSERT_SVH
`define PATH_HISTORY_FOLD_HASH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define PHFH_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PHFH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/phfh_pkg.sv @@
// ---------------------------------------------------------------------------
// phfh_pkg
// Types, constants and the footprint hash shared by the path history
// fold/hash block.
// ---------------------------------------------------------------------------
package phfh_pkg;

   // default sizing
   localparam int DEF_HISTORY_BITS = 388;
   localparam int DEF_INDEX_BITS   = 11;
   localparam int DEF_TAG_BITS     = 12;

   // field widths
   localparam int ADDR_W       = 32;
   localparam int FOLD_INDEX_W = 12;
   localparam int TAG_OUT_W    = 12;
   localparam int FOOTPRINT_W  = 16;
   localparam int RANGE_W      = 5;
   localparam int MOD_BITS_W   = 9;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 9;

   // fold geometry
   localparam int FOLD_TAPS      = 11;
   localparam int SHORT_TAP_HI   = 26;
   localparam int SHORT_TAP_LO   = 21;
   localparam int RANGE_STRIDE   = 22;
   localparam int EVEN_OFFSET    = 12;
   localparam int ODD_OFFSET     = 1;
   localparam int RANGE_COUNT    = 1 << RANGE_W;
   // zero padding above the history so every ranged tap has a bit to read
   localparam int HIST_PAD_BITS  = RANGE_STRIDE * RANGE_COUNT + EVEN_OFFSET;
   localparam int PC_INDEX_BIT   = 5;
   localparam int TAG_ROT        = 5;
   localparam int TAG_SHIFT      = 7;
   localparam int HIST_SHIFT     = 2;

   typedef enum logic [1:0] {
      FOLD_SHORT   = 2'd0,
      FOLD_RANGED  = 2'd1,
      FOLD_MODULAR = 2'd2,
      FOLD_OFF     = 2'd3
   } fold_mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FOLD_MODE  = 3'd0,
      CSR_EVEN_LOW   = 3'd1,
      CSR_EVEN_HIGH  = 3'd2,
      CSR_ODD_LOW    = 3'd3,
      CSR_ODD_HIGH   = 3'd4,
      CSR_MOD_BITS   = 3'd5
   } csr_index_type;

   typedef struct packed {
      fold_mode_type           fold_mode;
      logic [RANGE_W-1:0]      even_range_low;
      logic [RANGE_W-1:0]      even_range_high;
      logic [RANGE_W-1:0]      odd_range_low;
      logic [RANGE_W-1:0]      odd_range_high;
      logic [MOD_BITS_W-1:0]   modular_fold_bits;
   } cfg_type;

   typedef struct packed {
      logic                    en;
      logic [FOOTPRINT_W-1:0]  footprint;
   } hist_upd_type;

   localparam fold_mode_type         RST_FOLD_MODE  = FOLD_RANGED;
   localparam logic [RANGE_W-1:0]    RST_RANGE_LOW  = 5'd1;
   localparam logic [RANGE_W-1:0]    RST_RANGE_HIGH = 5'd5;
   localparam logic [MOD_BITS_W-1:0] RST_MOD_BITS   = 9'd388;

   // 16-bit branch/target footprint
   function automatic logic [FOOTPRINT_W-1:0] footprint(
      input logic [ADDR_W-1:0] b,
      input logic [ADDR_W-1:0] t
   );
      logic [FOOTPRINT_W-1:0] r;
      r[0]     = b[3]  ^ t[0];
      r[1]     = b[4]  ^ t[1];
      r[7:2]   = b[10:5];
      r[8]     = b[0]  ^ t[2];
      r[9]     = b[1]  ^ t[3];
      r[10]    = b[2]  ^ t[4];
      r[11]    = b[11] ^ t[5];
      r[15:12] = b[15:12];
      return r;
   endfunction

endpackage

@@ design/phfh_csr.sv @@
// ---------------------------------------------------------------------------
// phfh_csr
// Configuration registers of the fold/hash block, written by index.
// ---------------------------------------------------------------------------
module phfh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [phfh_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [phfh_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output phfh_pkg::cfg_type                   cfg_o
);
   import phfh_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FOLD_MODE: cfg_in.fold_mode         = fold_mode_type'(csr_wdata[1:0]);
            CSR_EVEN_LOW:  cfg_in.even_range_low    = csr_wdata[RANGE_W-1:0];
            CSR_EVEN_HIGH: cfg_in.even_range_high   = csr_wdata[RANGE_W-1:0];
            CSR_ODD_LOW:   cfg_in.odd_range_low     = csr_wdata[RANGE_W-1:0];
            CSR_ODD_HIGH:  cfg_in.odd_range_high    = csr_wdata[RANGE_W-1:0];
            CSR_MOD_BITS:  cfg_in.modular_fold_bits = csr_wdata[MOD_BITS_W-1:0];
            default: ;     // drop writes outside the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fold_mode         <= RST_FOLD_MODE;
         cfg_ff.even_range_low    <= RST_RANGE_LOW;
         cfg_ff.even_range_high   <= RST_RANGE_HIGH;
         cfg_ff.odd_range_low     <= RST_RANGE_LOW;
         cfg_ff.odd_range_high    <= RST_RANGE_HIGH;
         cfg_ff.modular_fold_bits <= RST_MOD_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

@@ design/phfh_hist.sv @@
// ---------------------------------------------------------------------------
// phfh_hist
// Path history register: shift left by two and XOR in the footprint on
// every taken branch.
// ---------------------------------------------------------------------------
module phfh_hist #(
   parameter int HISTORY_BITS = phfh_pkg::DEF_HISTORY_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  phfh_pkg::hist_upd_type    upd_i,
   output logic [HISTORY_BITS-1:0]   hist_o
);
   import phfh_pkg::*;

   logic [HISTORY_BITS-1:0] hist_ff;
   logic [HISTORY_BITS-1:0] hist_in;

   always_comb begin
      hist_in = hist_ff;
      if (upd_i.en) begin
         hist_in = {hist_ff[HISTORY_BITS-HIST_SHIFT-1:0], {HIST_SHIFT{1'b0}}}
                   ^ HISTORY_BITS'(upd_i.footprint);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   assign hist_o = hist_ff;

endmodule

@@ design/phfh_fold.sv @@
// ---------------------------------------------------------------------------
// phfh_fold
// XOR folds of the path history: mode-selected table index and the
// PC-mixed tag.
// ---------------------------------------------------------------------------
module phfh_fold #(
   parameter int HISTORY_BITS = phfh_pkg::DEF_HISTORY_BITS,
   parameter int INDEX_BITS   = phfh_pkg::DEF_INDEX_BITS,
   parameter int TAG_BITS     = phfh_pkg::DEF_TAG_BITS
) (
   input  logic [HISTORY_BITS-1:0]              hist_i,
   input  phfh_pkg::cfg_type                    cfg_i,
   input  logic [phfh_pkg::ADDR_W-1:0]          pc_i,
   output logic [phfh_pkg::FOLD_INDEX_W-1:0]    fold_index_o,
   output logic [phfh_pkg::TAG_OUT_W-1:0]       history_tag_o
);
   import phfh_pkg::*;

   localparam int               ExtBits = HISTORY_BITS + HIST_PAD_BITS;
   localparam logic [ADDR_W-1:0] TagMask = (ADDR_W'(1) << TAG_BITS) - ADDR_W'(1);

   logic [ExtBits-1:0]     h_ext;
   logic [FOLD_TAPS-1:0]   short_fold;
   logic [FOLD_TAPS-1:0]   ranged_fold;
   logic [RANGE_COUNT-1:0] even_en;
   logic [RANGE_COUNT-1:0] odd_en;
   logic [INDEX_BITS-1:0]  mod_fold;
   logic [TAG_BITS-1:0]    tag_fold;
   logic [ADDR_W-1:0]      tag_word;

   assign h_ext = {{HIST_PAD_BITS{1'b0}}, hist_i};

   always_comb begin
      for (int k = 0; k < FOLD_TAPS; k++) begin
         short_fold[k] = h_ext[SHORT_TAP_HI - 2*k] ^ h_ext[SHORT_TAP_LO - 2*k];
      end
   end

   always_comb begin
      for (int a = 0; a < RANGE_COUNT; a++) begin
         even_en[a] = (RANGE_W'(a) >= cfg_i.even_range_low) &&
                      (RANGE_W'(a) <= cfg_i.even_range_high);
         odd_en[a]  = (RANGE_W'(a) >= cfg_i.odd_range_low) &&
                      (RANGE_W'(a) <= cfg_i.odd_range_high);
      end
   end

   // each enabled range step XORs in eleven fixed taps; taps below zero drop out
   always_comb begin
      int pos;
      ranged_fold = '0;
      for (int a = 0; a < RANGE_COUNT; a++) begin
         for (int k = 0; k < FOLD_TAPS; k++) begin
            pos = RANGE_STRIDE*a + EVEN_OFFSET - 2*k;
            if (pos >= 0) begin
               ranged_fold[k] = ranged_fold[k] ^ (even_en[a] & h_ext[pos]);
            end
            pos = RANGE_STRIDE*a + ODD_OFFSET - 2*k;
            if (pos >= 0) begin
               ranged_fold[k] = ranged_fold[k] ^ (odd_en[a] & h_ext[pos]);
            end
         end
      end
   end

   // a count above the history length simply enables every bit
   always_comb begin
      mod_fold = '0;
      for (int i = 0; i < HISTORY_BITS; i++) begin
         if (i < int'(cfg_i.modular_fold_bits)) begin
            mod_fold[i % INDEX_BITS] = mod_fold[i % INDEX_BITS] ^ hist_i[i];
         end
      end
   end

   always_comb begin
      tag_fold = '0;
      for (int i = 0; i < HISTORY_BITS; i++) begin
         tag_fold[i % TAG_BITS] = tag_fold[i % TAG_BITS] ^ hist_i[i];
      end
   end

   // the rotated-in high bits land above the tag and drop out under the mask
   assign tag_word = (pc_i ^ (ADDR_W'(tag_fold) >> TAG_ROT)
                           ^ (ADDR_W'(tag_fold) >> TAG_SHIFT)) & TagMask;
   assign history_tag_o = tag_word[TAG_OUT_W-1:0];

   always_comb begin
      case (cfg_i.fold_mode)
         FOLD_SHORT:   fold_index_o = {pc_i[PC_INDEX_BIT], short_fold};
         FOLD_RANGED:  fold_index_o = {pc_i[PC_INDEX_BIT], ranged_fold};
         FOLD_MODULAR: fold_index_o = FOLD_INDEX_W'(mod_fold);
         default:      fold_index_o = '0;
      endcase
   end

endmodule

@@ design/path_history_fold_hash.sv @@
// ---------------------------------------------------------------------------
// path_history_fold_hash
// Branch path history register with folded index, tag and footprint hash.
// Usage:
//   The req_ stream carries one resolved branch per beat (address, target,
//   taken flag in tuser). Each beat yields one rsp_ beat: the folded index
//   and tag, both taken from the history as it stood before that branch,
//   and the 16-bit footprint. A taken branch then shifts the history left
//   by two and XORs the footprint into its low bits.
//   A req beat passes through the input register and then the result
//   register, with the XOR folds and the history update in between.
//   Throughput is one beat per cycle while rsp_tready is high.
//   The history advances when a taken beat moves into the result
//   register, so consecutive beats see each other's updates without bubbles.
//   When rsp_tready is low the result register holds and the input register
//   still takes one more beat; req_tready then drops until the result moves.
//   Reset (synchronous) clears the history and both valid flags and loads
//   the registers with their defaults. csr_ writes take effect on the next
//   cycle and must be made only while no beat is in flight (not enforced).
// ---------------------------------------------------------------------------
module path_history_fold_hash #(
   parameter int HISTORY_BITS = phfh_pkg::DEF_HISTORY_BITS,
   parameter int INDEX_BITS   = phfh_pkg::DEF_INDEX_BITS,
   parameter int TAG_BITS     = phfh_pkg::DEF_TAG_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: branch_addr[31:0], target_addr[63:32]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,
   // req_tuser: taken[0]
   input  logic                               req_tuser,
   // rsp_tdata: fold_index[11:0], history_tag[23:12], footprint_hash[39:24]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,
   input  logic                               csr_we,
   input  logic [phfh_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [phfh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import phfh_pkg::*;

   cfg_type                  cfg;
   hist_upd_type             upd;
   logic [HISTORY_BITS-1:0]  hist;

   logic                     stg_valid_ff, stg_valid_in;
   logic [ADDR_W-1:0]        stg_pc_ff;
   logic [ADDR_W-1:0]        stg_tgt_ff;
   logic                     stg_taken_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [39:0]              rsp_data_ff;

   logic                     advance;
   logic                     req_beat;
   logic [FOLD_INDEX_W-1:0]  fold_index;
   logic [TAG_OUT_W-1:0]     history_tag;
   logic [FOOTPRINT_W-1:0]   fp;

   phfh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   phfh_hist #(
      .HISTORY_BITS (HISTORY_BITS)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .upd_i  (upd),
      .hist_o (hist)
   );

   phfh_fold #(
      .HISTORY_BITS (HISTORY_BITS),
      .INDEX_BITS   (INDEX_BITS),
      .TAG_BITS     (TAG_BITS)
   ) u_fold (
      .hist_i        (hist),
      .cfg_i         (cfg),
      .pc_i          (stg_pc_ff),
      .fold_index_o  (fold_index),
      .history_tag_o (history_tag)
   );

   // move the staged beat on whenever the result slot is free or draining
   assign advance      = stg_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !stg_valid_ff || advance;
   assign req_beat     = req_tvalid && req_tready;
   assign stg_valid_in = req_beat || (stg_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   assign fp            = footprint(stg_pc_ff, stg_tgt_ff);
   assign upd.en        = advance && stg_taken_ff;
   assign upd.footprint = fp;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         stg_pc_ff    <= req_tdata[31:0];
         stg_tgt_ff   <= req_tdata[63:32];
         stg_taken_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= {fp, history_tag, fold_index};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "path_history_fold_hash_assert.svh"

   `PHFH_ASSERT_NEXT(a_hist_hold, clock, reset, !(advance && stg_taken_ff),
                     $stable(hist), "history changed without a taken beat moving on")
   `PHFH_ASSERT_NEXT(a_rsp_after_advance, clock, reset, advance, rsp_tvalid,
                     "result register empty after a beat moved in")
   `PHFH_ASSERT_NOW(a_stall_full, clock, reset, !req_tready,
                    stg_valid_ff && rsp_valid_ff && !rsp_tready,
                    "input stalled while a stage had room")
   `PHFH_ASSERT_NEXT(a_stg_hold, clock, reset, stg_valid_ff && !advance,
                     stg_valid_ff && $stable(stg_pc_ff),
                     "staged beat lost while the result side stalled")

endmodule

@@ test/path_history_fold_hash_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Path history fold/hash checker
// Watches the req_, rsp_ and csr_ ports, keeps a private copy of the
// history register and the fold settings, works out the index, tag and
// footprint for every accepted branch and compares each accepted result
// beat with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module path_history_fold_hash_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [63:0]                     req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [39:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [phfh_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [phfh_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   import phfh_pkg::*;

   localparam int HB  = DEF_HISTORY_BITS;
   localparam int IDX = DEF_INDEX_BITS;
   localparam int TB  = DEF_TAG_BITS;

   typedef struct packed {
      logic [FOLD_INDEX_W-1:0] fold_index;
      logic [TAG_OUT_W-1:0]    history_tag;
      logic [FOOTPRINT_W-1:0]  footprint_hash;
   } branch_result_type;

   branch_result_type     pending_results[$];
   logic [HB-1:0]         shadow_history;
   fold_mode_type         cur_mode;
   logic [RANGE_W-1:0]    even_lo, even_hi, odd_lo, odd_hi;
   logic [MOD_BITS_W-1:0] mod_count;

   function automatic logic hist_bit(input logic [HB-1:0] h, input int pos);
      if (pos < 0 || pos >= HB) return 1'b0;
      return h[pos];
   endfunction

   function automatic branch_result_type predict_branch(
      input logic [HB-1:0] h,
      input logic [31:0]   pc,
      input logic [31:0]   tgt
   );
      branch_result_type res;
      logic [IDX-1:0]    fold;
      logic [TB-1:0]     chunks;
      logic [31:0]       f32;
      logic [31:0]       tag32;
      logic [15:0]       fp;
      int                n;
      fold = '0;
      case (cur_mode)
         FOLD_SHORT: begin
            for (int k = 0; k < FOLD_TAPS; k++)
               fold[k] = hist_bit(h, 26 - 2 * k) ^ hist_bit(h, 21 - 2 * k);
         end
         FOLD_RANGED: begin
            // a low above its high gives no terms; out-of-range taps read zero
            for (int a = int'(even_lo); a <= int'(even_hi); a++)
               for (int k = 0; k < FOLD_TAPS; k++)
                  fold[k] ^= hist_bit(h, 22 * a + 12 - 2 * k);
            for (int a = int'(odd_lo); a <= int'(odd_hi); a++)
               for (int k = 0; k < FOLD_TAPS; k++)
                  fold[k] ^= hist_bit(h, 22 * a + 1 - 2 * k);
         end
         FOLD_MODULAR: begin
            n = int'(mod_count);
            if (n > HB) n = HB;
            for (int i = 0; i < n; i++)
               fold[i % IDX] ^= h[i];
         end
         default: fold = '0;
      endcase
      case (cur_mode)
         FOLD_SHORT, FOLD_RANGED: res.fold_index = {pc[5], fold};
         FOLD_MODULAR:            res.fold_index = {1'b0, fold};
         default:                 res.fold_index = '0;
      endcase

      chunks = '0;
      for (int i = 0; i < HB; i++)
         chunks[i % TB] ^= h[i];
      f32   = {{(32 - TB){1'b0}}, chunks};
      tag32 = pc ^ ((f32 >> 5) | (f32 << 27)) ^ (f32 >> 7);
      res.history_tag = tag32[TB-1:0];

      fp[0]     = pc[3]  ^ tgt[0];
      fp[1]     = pc[4]  ^ tgt[1];
      fp[7:2]   = pc[10:5];
      fp[8]     = pc[0]  ^ tgt[2];
      fp[9]     = pc[1]  ^ tgt[3];
      fp[10]    = pc[2]  ^ tgt[4];
      fp[11]    = pc[11] ^ tgt[5];
      fp[15:12] = pc[15:12];
      res.footprint_hash = fp;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < 10)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      branch_result_type want;
      if (reset) begin
         pending_results.delete();
         mismatches     = 0;
         shadow_history = '0;
         cur_mode       = RST_FOLD_MODE;
         even_lo        = RST_RANGE_LOW;
         even_hi        = RST_RANGE_HIGH;
         odd_lo         = RST_RANGE_LOW;
         odd_hi         = RST_RANGE_HIGH;
         mod_count      = RST_MOD_BITS;
      end else begin
         // compare first so that a beat pushed on this edge is never popped
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result beat", 32'h0, {8'h0, rsp_tdata[39:16]});
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[11:0] !== want.fold_index)
                  report_mismatch("fold_index", 32'(want.fold_index),
                                  32'(rsp_tdata[11:0]));
               if (rsp_tdata[23:12] !== want.history_tag)
                  report_mismatch("history_tag", 32'(want.history_tag),
                                  32'(rsp_tdata[23:12]));
               if (rsp_tdata[39:24] !== want.footprint_hash)
                  report_mismatch("footprint_hash", 32'(want.footprint_hash),
                                  32'(rsp_tdata[39:24]));
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_branch(shadow_history, req_tdata[31:0], req_tdata[63:32]);
            pending_results.push_back(want);
            if (req_tuser)
               shadow_history = {shadow_history[HB-3:0], 2'b00}
                                ^ {{(HB - FOOTPRINT_W){1'b0}}, want.footprint_hash};
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_FOLD_MODE: cur_mode  = fold_mode_type'(csr_wdata[1:0]);
               CSR_EVEN_LOW:  even_lo   = csr_wdata[RANGE_W-1:0];
               CSR_EVEN_HIGH: even_hi   = csr_wdata[RANGE_W-1:0];
               CSR_ODD_LOW:   odd_lo    = csr_wdata[RANGE_W-1:0];
               CSR_ODD_HIGH:  odd_hi    = csr_wdata[RANGE_W-1:0];
               CSR_MOD_BITS:  mod_count = csr_wdata[MOD_BITS_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = pending_results.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Path history fold/hash testbench
// Drives resolved branches into the block under every fold setting, with
// random gaps on both streams, one long result stall and a drain before
// each register change. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module testbench;
   import phfh_pkg::*;

   localparam int  LONG_HOLD_CYCLES = 300;
   localparam int  SETTLE_CYCLES    = 4;
   localparam real TIMEOUT_NS       = 800000.0 * 20.0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_B = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int   mismatches;
   int   outstanding;
   int   idle_pct      = 0;
   logic long_hold_req = 1'b0;

   always #10 clock = ~clock;

   path_history_fold_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   path_history_fold_hash_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_branch(input logic [31:0] pc, input logic [31:0] tgt,
                              input logic tk);
      int gap;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tgt, pc};
      req_tuser  <= tk;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and hold until every predicted beat has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input fold_mode_type mode,
                             input logic [RANGE_W-1:0] el, input logic [RANGE_W-1:0] eh,
                             input logic [RANGE_W-1:0] ol, input logic [RANGE_W-1:0] oh,
                             input logic [MOD_BITS_W-1:0] mb);
      drain();
      write_reg(CSR_FOLD_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_EVEN_LOW,  CSR_DATA_W'(el));
      write_reg(CSR_EVEN_HIGH, CSR_DATA_W'(eh));
      write_reg(CSR_ODD_LOW,   CSR_DATA_W'(ol));
      write_reg(CSR_ODD_HIGH,  CSR_DATA_W'(oh));
      write_reg(CSR_MOD_BITS,  mb);
   endtask

   task automatic random_branches(input int count);
      for (int n = 0; n < count; n++)
         send_branch($urandom, $urandom, $urandom_range(0, 99) < 70);
   endtask

   // result side: random back-pressure plus the long hold on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            hold_left = gap_len() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, history starting from empty
      idle_pct = 0;
      send_branch(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_branch(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      send_branch(32'h0000_0020, 32'h0000_0000, 1'b0);
      send_branch(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      send_branch(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      // fixed short fold
      set_config(FOLD_SHORT, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      send_branch(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
      send_branch(32'hFFFF_FFDF, 32'h0000_003F, 1'b1);
      send_branch(32'h0000_0020, 32'hFFFF_FFC0, 1'b0);
      // modular fold with a zero count, then a count past the history length
      set_config(FOLD_MODULAR, 5'd1, 5'd5, 5'd1, 5'd5, 9'd0);
      send_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_branch(32'h0000_0000, 32'h0000_0000, 1'b0);
      set_config(FOLD_MODULAR, 5'd1, 5'd5, 5'd1, 5'd5, 9'd511);
      send_branch(32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1);
      send_branch(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
      // index off
      set_config(FOLD_OFF, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      send_branch(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_branch(32'h0000_0020, 32'hFFFF_FFFF, 1'b0);
      // writes to indexes outside the list must change nothing
      drain();
      write_reg(CSR_SPARE_A, 9'h1FF);
      write_reg(CSR_SPARE_B, 9'h000);
      send_branch(32'h8000_0001, 32'h7FFF_FFFE, 1'b1);
      // empty ranges, then ranges beyond the usual limits
      set_config(FOLD_RANGED, 5'd9, 5'd3, 5'd12, 5'd2, 9'd388);
      send_branch(32'h0000_FFFF, 32'hFFFF_0000, 1'b1);
      send_branch(32'hFFFF_0000, 32'h0000_FFFF, 1'b0);
      set_config(FOLD_RANGED, 5'd0, 5'd31, 5'd0, 5'd31, 9'd388);
      send_branch(32'h3C3C_3C3C, 32'hC3C3_C3C3, 1'b1);
      send_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

      // random part
      idle_pct = 25;
      set_config(FOLD_RANGED, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      random_branches(200);
      idle_pct = 0;
      set_config(FOLD_SHORT, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      random_branches(150);
      idle_pct = 25;
      set_config(FOLD_MODULAR, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      // stall the result side for a long stretch while branches keep coming
      long_hold_req = 1'b1;
      random_branches(150);
      set_config(FOLD_MODULAR, 5'd1, 5'd5, 5'd1, 5'd5, 9'd1);
      random_branches(80);
      set_config(FOLD_MODULAR, 5'd1, 5'd5, 5'd1, 5'd5, 9'd0);
      random_branches(60);
      set_config(FOLD_MODULAR, 5'd1, 5'd5, 5'd1, 5'd5, 9'd511);
      random_branches(100);
      idle_pct = 40;
      set_config(FOLD_RANGED, 5'd1, 5'd17, 5'd1, 5'd17, 9'd388);
      random_branches(200);
      idle_pct = 20;
      set_config(FOLD_RANGED, 5'd17, 5'd17, 5'd17, 5'd17, 9'd388);
      random_branches(80);
      set_config(FOLD_RANGED, 5'd0, 5'd31, 5'd0, 5'd31, 9'd388);
      random_branches(120);
      set_config(FOLD_RANGED, 5'd9, 5'd3, 5'd12, 5'd2, 9'd388);
      random_branches(80);
      for (int p = 0; p < 6; p++) begin
         idle_pct = $urandom_range(0, 40);
         set_config(fold_mode_type'($urandom_range(0, 3)),
                    RANGE_W'($urandom_range(0, 31)), RANGE_W'($urandom_range(0, 31)),
                    RANGE_W'($urandom_range(1, 17)), RANGE_W'($urandom_range(1, 17)),
                    MOD_BITS_W'($urandom_range(0, 511)));
         random_branches(60);
      end
      idle_pct = 20;
      set_config(FOLD_OFF, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      random_branches(60);
      idle_pct = 0;
      set_config(FOLD_RANGED, 5'd1, 5'd5, 5'd1, 5'd5, 9'd388);
      random_branches(150);

      drain();
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
